// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/phc_pkg.sv
package phc_pkg;

    // opcodes
    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_START_LEADER = 3'd1;
    localparam logic [2:0] OP_START_MEMBER = 3'd2;
    localparam logic [2:0] OP_STOP         = 3'd3;
    localparam logic [2:0] OP_BEACON_RX    = 3'd4;
    localparam logic [2:0] OP_JOIN_RX      = 3'd5;
    localparam logic [2:0] OP_KEY_RX       = 3'd6;

    // result kinds
    localparam logic [2:0] KIND_STATE     = 3'd0;
    localparam logic [2:0] KIND_BEACON    = 3'd1;
    localparam logic [2:0] KIND_JOIN      = 3'd2;
    localparam logic [2:0] KIND_KEY       = 3'd3;
    localparam logic [2:0] KIND_INSTALLED = 3'd4;

    // roles
    localparam logic [1:0] ROLE_NONE   = 2'd0;
    localparam logic [1:0] ROLE_LEADER = 2'd1;
    localparam logic [1:0] ROLE_MEMBER = 2'd2;

    // phase codes as reported on the result port
    localparam logic [2:0] PC_IDLE     = 3'd0;
    localparam logic [2:0] PC_BEACON   = 3'd1;
    localparam logic [2:0] PC_SCAN     = 3'd2;
    localparam logic [2:0] PC_JOINSENT = 3'd3;
    localparam logic [2:0] PC_WAITKEY  = 3'd4;
    localparam logic [2:0] PC_DONE     = 3'd5;
    localparam logic [2:0] PC_FAIL     = 3'd6;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_TEAM_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_KEY_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_NODE_ID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_NODE_ID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 3'd4;

    localparam logic [47:0] DEST_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [2:0]  TRIES_SAT  = 3'd7;
    localparam int unsigned MAX_RES    = 3;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_BEACON   = 7'b0000010,
        PH_SCAN     = 7'b0000100,
        PH_JOINSENT = 7'b0001000,
        PH_WAITKEY  = 7'b0010000,
        PH_DONE     = 7'b0100000,
        PH_FAIL     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
        logic [31:0] nonce_in;
        logic [63:0] frame_team_id;
        logic [31:0] frame_key_id;
        logic [31:0] frame_leader_id;
        logic [31:0] frame_member_id;
        logic [47:0] sender_addr;
        logic        link_ok;
    } in_t;

    typedef struct packed {
        logic [63:0] leader_team_id;
        logic [31:0] leader_key_id;
        logic [31:0] leader_node_id;
        logic [31:0] member_node_id;
        logic [5:0]  key_length;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  role;
        logic [2:0]  phase;
        logic [31:0] peer_id;
        logic [63:0] team_id;
        logic        team_known;
        logic [31:0] key_id;
        logic [47:0] dest_addr;
        logic [31:0] nonce;
        logic [31:0] leader_id;
        logic        last;
    } res_t;

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        case (p)
            PH_IDLE:     c = PC_IDLE;
            PH_BEACON:   c = PC_BEACON;
            PH_SCAN:     c = PC_SCAN;
            PH_JOINSENT: c = PC_JOINSENT;
            PH_WAITKEY:  c = PC_WAITKEY;
            PH_DONE:     c = PC_DONE;
            PH_FAIL:     c = PC_FAIL;
            default:     c = PC_IDLE;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/phc_engine.sv
module phc_engine #(
    parameter int LEADER_WINDOW_MS   = 120000,
    parameter int MEMBER_TIMEOUT_MS  = 30000,
    parameter int BEACON_INTERVAL_MS = 600,
    parameter int JOIN_RETRY_MS      = 1500,
    parameter int JOIN_RETRY_MAX     = 6,
    parameter int JOIN_HOLD_MS       = 800
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  phc_pkg::in_t            ev,
    input  phc_pkg::cfg_t           cfg,
    output phc_pkg::res_t [2:0]     res,
    output logic [1:0]              res_cnt
);
    import phc_pkg::*;

    localparam logic [31:0] LW_MS    = 32'(LEADER_WINDOW_MS);
    localparam logic [31:0] MT_MS    = 32'(MEMBER_TIMEOUT_MS);
    localparam logic [31:0] BI_MS    = 32'(BEACON_INTERVAL_MS);
    localparam logic [31:0] RETRY_MS = 32'(JOIN_RETRY_MS);
    localparam logic [31:0] HOLD_MS  = 32'(JOIN_HOLD_MS);
    localparam logic [2:0]  RETRY_N  = 3'(JOIN_RETRY_MAX);

    logic [1:0]  role_reg, role_next;
    phase_t      phase_reg, phase_next;
    logic [63:0] team_id_reg, team_id_next;
    logic        team_known_reg, team_known_next;
    logic [31:0] key_id_reg, key_id_next;
    logic [31:0] leader_id_reg, leader_id_next;
    logic [47:0] leader_addr_reg, leader_addr_next;
    logic        addr_valid_reg, addr_valid_next;
    logic [31:0] join_nonce_reg, join_nonce_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] beacon_at_reg, beacon_at_next;
    logic [31:0] join_at_reg, join_at_next;
    logic [31:0] sent_at_reg, sent_at_next;
    logic [2:0]  tries_reg, tries_next;
    logic [31:0] member_id_reg, member_id_next;

    logic expired, beacon_due, retry_due, hold_done;

    function automatic res_t mk(
        input logic [2:0]  kind,
        input logic [1:0]  role,
        input phase_t      phase,
        input logic        known,
        input logic [63:0] team,
        input logic [31:0] key,
        input logic [31:0] peer,
        input logic [47:0] dest,
        input logic [31:0] nonce,
        input logic [31:0] lead
    );
        res_t r;
        r.kind       = kind;
        r.role       = role;
        r.phase      = phase_code(phase);
        r.peer_id    = peer;
        r.team_id    = known ? team : 64'd0;
        r.team_known = known;
        r.key_id     = key;
        r.dest_addr  = dest;
        r.nonce      = nonce;
        r.leader_id  = lead;
        r.last       = 1'b0;
        return r;
    endfunction

    // millisecond comparisons: expiry against an absolute deadline, intervals by wrapping difference
    assign expired    = (deadline_reg != 32'd0) && (ev.now_ms >= deadline_reg);
    assign beacon_due = (ev.now_ms - beacon_at_reg) >= BI_MS;
    assign retry_due  = (ev.now_ms - join_at_reg) >= RETRY_MS;
    assign hold_done  = (ev.now_ms - sent_at_reg) >= HOLD_MS;

    always_comb
    begin
        role_next        = role_reg;
        phase_next       = phase_reg;
        team_id_next     = team_id_reg;
        team_known_next  = team_known_reg;
        key_id_next      = key_id_reg;
        leader_id_next   = leader_id_reg;
        leader_addr_next = leader_addr_reg;
        addr_valid_next  = addr_valid_reg;
        join_nonce_next  = join_nonce_reg;
        deadline_next    = deadline_reg;
        beacon_at_next   = beacon_at_reg;
        join_at_next     = join_at_reg;
        sent_at_next     = sent_at_reg;
        tries_next       = tries_reg;
        member_id_next   = member_id_reg;
        res_cnt          = 2'd0;
        res              = '0;

        case (ev.opcode)
            OP_TICK:
            begin
                case (phase_reg)
                    PH_BEACON:
                    begin
                        if (expired)
                        begin
                            res[0] = mk(KIND_STATE, role_reg, PH_FAIL, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res[1] = mk(KIND_STATE, ROLE_NONE, PH_IDLE, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res_cnt    = 2'd2;
                            role_next  = ROLE_NONE;
                            phase_next = PH_IDLE;
                        end
                        else if (beacon_due)
                        begin
                            res[0] = mk(KIND_BEACON, role_reg, phase_reg, team_known_reg,
                                        team_id_reg, key_id_reg, leader_id_reg, DEST_BCAST,
                                        32'd0, leader_id_reg);
                            res_cnt = 2'd1;
                            if (ev.link_ok)
                            begin
                                beacon_at_next = ev.now_ms;
                            end
                        end
                    end
                    PH_SCAN:
                    begin
                        if (expired)
                        begin
                            res[0] = mk(KIND_STATE, role_reg, PH_FAIL, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res[1] = mk(KIND_STATE, ROLE_NONE, PH_IDLE, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res_cnt    = 2'd2;
                            role_next  = ROLE_NONE;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_JOINSENT:
                    begin
                        // hold elapsed and expiry can both fire in one tick
                        if (hold_done)
                        begin
                            res[0] = mk(KIND_STATE, role_reg, PH_WAITKEY, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            phase_next = PH_WAITKEY;
                        end
                        if (expired)
                        begin
                            res[hold_done ? 2'd1 : 2'd0] =
                                mk(KIND_STATE, role_reg, PH_FAIL, team_known_reg,
                                   team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res[hold_done ? 2'd2 : 2'd1] =
                                mk(KIND_STATE, ROLE_NONE, PH_IDLE, team_known_reg,
                                   team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            role_next  = ROLE_NONE;
                            phase_next = PH_IDLE;
                        end
                        res_cnt = {1'b0, hold_done} + (expired ? 2'd2 : 2'd0);
                    end
                    PH_WAITKEY:
                    begin
                        if (expired)
                        begin
                            res[0] = mk(KIND_STATE, role_reg, PH_FAIL, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res[1] = mk(KIND_STATE, ROLE_NONE, PH_IDLE, team_known_reg,
                                        team_id_reg, key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                            res_cnt    = 2'd2;
                            role_next  = ROLE_NONE;
                            phase_next = PH_IDLE;
                        end
                        else if (addr_valid_reg && retry_due && (tries_reg < RETRY_N))
                        begin
                            res[0] = mk(KIND_JOIN, role_reg, phase_reg, team_known_reg,
                                        team_id_reg, key_id_reg, member_id_reg,
                                        leader_addr_reg, join_nonce_reg, 32'd0);
                            res_cnt = 2'd1;
                            if (ev.link_ok)
                            begin
                                join_at_next = ev.now_ms;
                                if (tries_reg != TRIES_SAT)
                                begin
                                    tries_next = tries_reg + 3'd1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_START_LEADER:
            begin
                if (cfg.key_length != 6'd0)
                begin
                    role_next       = ROLE_LEADER;
                    phase_next      = PH_BEACON;
                    team_id_next    = cfg.leader_team_id;
                    team_known_next = 1'b1;
                    key_id_next     = cfg.leader_key_id;
                    leader_id_next  = cfg.leader_node_id;
                    deadline_next   = ev.now_ms + LW_MS;
                    beacon_at_next  = 32'd0;
                    tries_next      = 3'd0;
                    sent_at_next    = 32'd0;
                    res[0] = mk(KIND_STATE, ROLE_LEADER, PH_BEACON, 1'b1, cfg.leader_team_id,
                                cfg.leader_key_id, 32'd0, 48'd0, 32'd0, 32'd0);
                    res_cnt = 2'd1;
                end
            end
            OP_START_MEMBER:
            begin
                role_next       = ROLE_MEMBER;
                phase_next      = PH_SCAN;
                member_id_next  = cfg.member_node_id;
                leader_id_next  = 32'd0;
                addr_valid_next = 1'b0;
                team_known_next = 1'b0;
                key_id_next     = 32'd0;
                join_nonce_next = ev.nonce_in;
                deadline_next   = ev.now_ms + MT_MS;
                join_at_next    = 32'd0;
                tries_next      = 3'd0;
                sent_at_next    = 32'd0;
                res[0] = mk(KIND_STATE, ROLE_MEMBER, PH_SCAN, 1'b0, team_id_reg, 32'd0,
                            32'd0, 48'd0, 32'd0, 32'd0);
                res_cnt = 2'd1;
            end
            OP_STOP:
            begin
                role_next  = ROLE_NONE;
                phase_next = PH_IDLE;
                res[0] = mk(KIND_STATE, ROLE_NONE, PH_IDLE, team_known_reg, team_id_reg,
                            key_id_reg, 32'd0, 48'd0, 32'd0, 32'd0);
                res_cnt = 2'd1;
            end
            OP_BEACON_RX:
            begin
                if ((role_reg == ROLE_MEMBER) && ((phase_reg == PH_SCAN) ||
                    (phase_reg == PH_JOINSENT) || (phase_reg == PH_WAITKEY)))
                begin
                    team_id_next     = ev.frame_team_id;
                    team_known_next  = 1'b1;
                    key_id_next      = ev.frame_key_id;
                    leader_id_next   = ev.frame_leader_id;
                    leader_addr_next = ev.sender_addr;
                    addr_valid_next  = 1'b1;
                    join_nonce_next  = ev.nonce_in;
                    tries_next       = 3'd0;
                    if (ev.link_ok)
                    begin
                        join_at_next = ev.now_ms;
                        tries_next   = 3'd1;
                    end
                    sent_at_next = ev.now_ms;
                    phase_next   = PH_JOINSENT;
                    res[0] = mk(KIND_JOIN, role_reg, phase_reg, 1'b1, ev.frame_team_id,
                                ev.frame_key_id, member_id_reg, ev.sender_addr,
                                ev.nonce_in, 32'd0);
                    res[1] = mk(KIND_STATE, role_reg, PH_JOINSENT, 1'b1, ev.frame_team_id,
                                ev.frame_key_id, 32'd0, 48'd0, 32'd0, 32'd0);
                    res_cnt = 2'd2;
                end
            end
            OP_JOIN_RX:
            begin
                if ((role_reg == ROLE_LEADER) && (phase_reg == PH_BEACON) &&
                    team_known_reg && (ev.frame_team_id == team_id_reg))
                begin
                    res[0] = mk(KIND_KEY, role_reg, phase_reg, team_known_reg, team_id_reg,
                                key_id_reg, ev.frame_member_id, ev.sender_addr,
                                ev.nonce_in, leader_id_reg);
                    // refused key frame: no follow-up state event
                    res[1] = mk(KIND_STATE, role_reg, phase_reg, team_known_reg, team_id_reg,
                                key_id_reg, ev.frame_member_id, 48'd0, 32'd0, 32'd0);
                    res_cnt = ev.link_ok ? 2'd2 : 2'd1;
                end
            end
            OP_KEY_RX:
            begin
                if ((role_reg == ROLE_MEMBER) &&
                    ((phase_reg == PH_WAITKEY) || (phase_reg == PH_JOINSENT)) &&
                    team_known_reg && (ev.frame_team_id == team_id_reg) &&
                    (ev.nonce_in == join_nonce_reg))
                begin
                    key_id_next = ev.frame_key_id;
                    role_next   = ROLE_NONE;
                    phase_next  = PH_IDLE;
                    res[0] = mk(KIND_INSTALLED, role_reg, phase_reg, 1'b1, team_id_reg,
                                ev.frame_key_id, leader_id_reg, 48'd0, 32'd0, leader_id_reg);
                    res[1] = mk(KIND_STATE, role_reg, PH_DONE, 1'b1, team_id_reg,
                                ev.frame_key_id, leader_id_reg, 48'd0, 32'd0, 32'd0);
                    res[2] = mk(KIND_STATE, ROLE_NONE, PH_IDLE, 1'b1, team_id_reg,
                                ev.frame_key_id, 32'd0, 48'd0, 32'd0, 32'd0);
                    res_cnt = 2'd3;
                end
            end
            default:
            begin
            end
        endcase

        case (res_cnt)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: res[0].last = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg        <= ROLE_NONE;
            phase_reg       <= PH_IDLE;
            team_id_reg     <= 64'd0;
            team_known_reg  <= 1'b0;
            key_id_reg      <= 32'd0;
            leader_id_reg   <= 32'd0;
            leader_addr_reg <= 48'd0;
            addr_valid_reg  <= 1'b0;
            join_nonce_reg  <= 32'd0;
            deadline_reg    <= 32'd0;
            beacon_at_reg   <= 32'd0;
            join_at_reg     <= 32'd0;
            sent_at_reg     <= 32'd0;
            tries_reg       <= 3'd0;
            member_id_reg   <= 32'd0;
        end
        else if (step)
        begin
            role_reg        <= role_next;
            phase_reg       <= phase_next;
            team_id_reg     <= team_id_next;
            team_known_reg  <= team_known_next;
            key_id_reg      <= key_id_next;
            leader_id_reg   <= leader_id_next;
            leader_addr_reg <= leader_addr_next;
            addr_valid_reg  <= addr_valid_next;
            join_nonce_reg  <= join_nonce_next;
            deadline_reg    <= deadline_next;
            beacon_at_reg   <= beacon_at_next;
            join_at_reg     <= join_at_next;
            sent_at_reg     <= sent_at_next;
            tries_reg       <= tries_next;
            member_id_reg   <= member_id_next;
        end
    end

`include "assert_macros.svh"

    `PHC_ASSERT(a_role_idle, ((role_reg == ROLE_NONE) == (phase_reg == PH_IDLE)), "role and phase disagree on idle")
    `PHC_ASSERT(a_leader_beacon, ((role_reg == ROLE_LEADER) |-> (phase_reg == PH_BEACON)), "leader outside beaconing")
    `PHC_ASSERT(a_addr_team, (addr_valid_reg |-> team_known_reg), "leader address held without a team")

endmodule

// File: hdl/pairing_handshake_controller.sv
// Pairing handshake controller. Each input transaction is one event (tick, start leader,
// start member, stop, or a decoded beacon, join or key frame) stamped with the current
// millisecond time; the block answers with zero to three result transactions (state
// events, send-beacon/join/key commands, key-installed notice), the final one marked
// by last_out. An event is held in an input register, evaluated combinationally by
// the engine, and its results are loaded into a three-entry result queue that drains
// one transaction per cycle unless out_stall is set. Throughput is one event per cycle
// while events produce at most one result and out_stall is clear, else the queue's single
// output port sets the pace. Events are registered on input and results in the queue.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata and should
// only change while no event is in flight. Timer constants are module parameters.
module pairing_handshake_controller #(
    parameter int LEADER_WINDOW_MS   = 120000,
    parameter int MEMBER_TIMEOUT_MS  = 30000,
    parameter int BEACON_INTERVAL_MS = 600,
    parameter int JOIN_RETRY_MS      = 1500,
    parameter int JOIN_RETRY_MAX     = 6,
    parameter int JOIN_HOLD_MS       = 800
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [phc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_wdata,

    // event channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      opcode,
    input  logic [31:0]                     now_ms,
    input  logic [31:0]                     nonce_in,
    input  logic [63:0]                     frame_team_id,
    input  logic [31:0]                     frame_key_id,
    input  logic [31:0]                     frame_leader_id,
    input  logic [31:0]                     frame_member_id,
    input  logic [47:0]                     sender_addr,
    input  logic                            link_ok,

    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      result_kind,
    output logic [1:0]                      role_out,
    output logic [2:0]                      phase_out,
    output logic [31:0]                     peer_id_out,
    output logic [63:0]                     team_id_out,
    output logic                            team_known_out,
    output logic [31:0]                     key_id_out,
    output logic [47:0]                     dest_addr,
    output logic [31:0]                     nonce_out,
    output logic [31:0]                     leader_id_out,
    output logic                            last_out
);
    import phc_pkg::*;

    cfg_t        cfg_reg;
    in_t         in_reg;
    logic        in_valid_reg;
    res_t        res_buf_reg [MAX_RES];
    logic [1:0]  res_cnt_reg;

    res_t [2:0]  eng_res;
    logic [1:0]  eng_cnt;
    logic        in_take;
    logic        pop;
    logic        process;

    // Config registers; out-of-range indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LEADER_TEAM_ID: cfg_reg.leader_team_id <= cfg_wdata;
                CFG_LEADER_KEY_ID:  cfg_reg.leader_key_id  <= cfg_wdata[31:0];
                CFG_LEADER_NODE_ID: cfg_reg.leader_node_id <= cfg_wdata[31:0];
                CFG_MEMBER_NODE_ID: cfg_reg.member_node_id <= cfg_wdata[31:0];
                CFG_KEY_LENGTH:     cfg_reg.key_length     <= cfg_wdata[5:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Queue head pops on a completed output transaction. The held event is evaluated
    // once the queue will be empty after this cycle, so its results never mix with
    // those of the previous event.
    assign pop      = out_valid && !out_stall;
    assign process  = in_valid_reg && ((res_cnt_reg == 2'd0) ||
                                       ((res_cnt_reg == 2'd1) && pop));
    assign in_stall = in_valid_reg && !process;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.opcode          <= opcode;
            in_reg.now_ms          <= now_ms;
            in_reg.nonce_in        <= nonce_in;
            in_reg.frame_team_id   <= frame_team_id;
            in_reg.frame_key_id    <= frame_key_id;
            in_reg.frame_leader_id <= frame_leader_id;
            in_reg.frame_member_id <= frame_member_id;
            in_reg.sender_addr     <= sender_addr;
            in_reg.link_ok         <= link_ok;
        end
    end

    phc_engine #(
        .LEADER_WINDOW_MS   (LEADER_WINDOW_MS),
        .MEMBER_TIMEOUT_MS  (MEMBER_TIMEOUT_MS),
        .BEACON_INTERVAL_MS (BEACON_INTERVAL_MS),
        .JOIN_RETRY_MS      (JOIN_RETRY_MS),
        .JOIN_RETRY_MAX     (JOIN_RETRY_MAX),
        .JOIN_HOLD_MS       (JOIN_HOLD_MS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (process),
        .ev      (in_reg),
        .cfg     (cfg_reg),
        .res     (eng_res),
        .res_cnt (eng_cnt)
    );

    // Result queue: loaded whole on process, shifts toward the head on pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 2'd0;
        end
        else if (process)
        begin
            res_cnt_reg <= eng_cnt;
        end
        else if (pop)
        begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            res_buf_reg[0] <= eng_res[0];
            res_buf_reg[1] <= eng_res[1];
            res_buf_reg[2] <= eng_res[2];
        end
        else if (pop)
        begin
            res_buf_reg[0] <= res_buf_reg[1];
            res_buf_reg[1] <= res_buf_reg[2];
        end
    end

    assign out_valid      = (res_cnt_reg != 2'd0);
    assign result_kind    = res_buf_reg[0].kind;
    assign role_out       = res_buf_reg[0].role;
    assign phase_out      = res_buf_reg[0].phase;
    assign peer_id_out    = res_buf_reg[0].peer_id;
    assign team_id_out    = res_buf_reg[0].team_id;
    assign team_known_out = res_buf_reg[0].team_known;
    assign key_id_out     = res_buf_reg[0].key_id;
    assign dest_addr      = res_buf_reg[0].dest_addr;
    assign nonce_out      = res_buf_reg[0].nonce;
    assign leader_id_out  = res_buf_reg[0].leader_id;
    assign last_out       = res_buf_reg[0].last;

`include "assert_macros.svh"

    // last marker sits on exactly the final queued result of an event
    `PHC_ASSERT(a_last_mark, (out_valid |-> (last_out == (res_cnt_reg == 2'd1))), "last_out misplaced in result queue")
    // an evaluated event leaves the input register unless a new one arrives
    `PHC_ASSERT_NEXT(a_in_drain, process && !in_take, !in_valid_reg, "input register not freed after evaluation")

endmodule

// File: tb/sv/pairing_handshake_controller_tb.sv
`timescale 1ns / 100ps

module pairing_handshake_controller_tb;
    import phc_pkg::*;

    // Timer constants, same values as the block's default parameters.
    localparam int unsigned WINDOW_MS   = 120000;
    localparam int unsigned MEMBER_MS   = 30000;
    localparam int unsigned BEACON_MS   = 600;
    localparam int unsigned RETRY_MS    = 1500;
    localparam int unsigned RETRY_LIMIT = 6;
    localparam int unsigned HOLD_MS     = 800;

    // Opcode seven has no meaning; the block must drop it silently.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;      // input register + engine + result queue, with margin
    localparam int HOLD_CYCLES   = 400;    // one long receiver hold-off
    localparam int HOLD_AFTER    = 150;    // ...started once this many events went in
    localparam int TIMEOUT_NS    = 3000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_wdata = '0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           opcode = '0;
    logic [31:0]          now_ms = '0;
    logic [31:0]          nonce_in = '0;
    logic [63:0]          frame_team_id = '0;
    logic [31:0]          frame_key_id = '0;
    logic [31:0]          frame_leader_id = '0;
    logic [31:0]          frame_member_id = '0;
    logic [47:0]          sender_addr = '0;
    logic                 link_ok = 1'b0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           result_kind;
    logic [1:0]           role_out;
    logic [2:0]           phase_out;
    logic [31:0]          peer_id_out;
    logic [63:0]          team_id_out;
    logic                 team_known_out;
    logic [31:0]          key_id_out;
    logic [47:0]          dest_addr;
    logic [31:0]          nonce_out;
    logic [31:0]          leader_id_out;
    logic                 last_out;

    pairing_handshake_controller dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the handshake: configuration, set when it is loaded, and
    // session state, updated once per accepted event transaction.
    // ------------------------------------------------------------------
    logic [63:0] cfg_team = '0;
    logic [31:0] cfg_key = '0;
    logic [31:0] cfg_leader = '0;
    logic [31:0] cfg_member = '0;
    logic [5:0]  cfg_klen = '0;

    logic [1:0]  role_q = ROLE_NONE;
    logic [2:0]  phase_q = PC_IDLE;
    logic [63:0] team_q = '0;
    logic        team_ok_q = 1'b0;
    logic [31:0] key_q = '0;
    logic [31:0] leader_q = '0;
    logic [47:0] leader_mac_q = '0;
    logic        leader_mac_ok_q = 1'b0;
    logic [31:0] nonce_q = '0;
    logic [31:0] deadline_q = '0;
    logic [31:0] beacon_at_q = '0;
    logic [31:0] join_at_q = '0;
    logic [31:0] join_sent_q = '0;
    logic [2:0]  tries_q = '0;
    logic [31:0] my_member_q = '0;

    // Results the block still owes, oldest first. The newest result of the
    // event being evaluated is held back so its last flag can be set.
    res_t        outbox_q[$];
    res_t        held_res;
    bit          have_held = 1'b0;

    in_t         event_q[$];       // event transactions not yet offered
    in_t         on_wire;          // event currently presented to the block
    bit          item_on_wire = 1'b0;
    int          accepted_cnt = 0;
    int          fail_cnt = 0;
    int          items_made = 0;
    logic [31:0] ms_clock = '0;    // stimulus time base

    function automatic void note_result(input logic [2:0] kind, input logic [31:0] peer,
                                        input logic [47:0] dest, input logic [31:0] nonce,
                                        input logic [31:0] lead);
        res_t r;
        if (have_held)
            outbox_q.push_back(held_res);
        r.kind       = kind;
        r.role       = role_q;
        r.phase      = phase_q;
        r.peer_id    = peer;
        r.team_id    = team_ok_q ? team_q : 64'd0;
        r.team_known = team_ok_q;
        r.key_id     = key_q;
        r.dest_addr  = dest;
        r.nonce      = nonce;
        r.leader_id  = lead;
        r.last       = 1'b0;
        held_res  = r;
        have_held = 1'b1;
    endfunction

    function automatic void enter_phase(input logic [2:0] ph, input logic [31:0] peer);
        phase_q = ph;
        note_result(KIND_STATE, peer, '0, '0, '0);
    endfunction

    function automatic void drop_to_idle();
        role_q = ROLE_NONE;
        enter_phase(PC_IDLE, '0);
    endfunction

    // Timeout: failed event first, then back to idle with no role.
    function automatic void abort_session();
        enter_phase(PC_FAIL, '0);
        drop_to_idle();
    endfunction

    // A zero deadline never fires.
    function automatic logic deadline_hit(input logic [31:0] t);
        return deadline_q != 32'd0 && t >= deadline_q;
    endfunction

    // A refused send is still reported; only an accepted one moves time and tries.
    function automatic void issue_join(input logic [31:0] t, input logic ok);
        if (leader_mac_ok_q)
        begin
            note_result(KIND_JOIN, my_member_q, leader_mac_q, nonce_q, '0);
            if (ok)
            begin
                join_at_q = t;
                if (tries_q < TRIES_SAT)
                    tries_q = tries_q + 3'd1;
            end
        end
    endfunction

    function automatic void on_tick(input logic [31:0] t, input logic ok);
        logic [31:0] since_beacon;
        logic [31:0] since_sent;
        logic [31:0] since_join;
        since_beacon = t - beacon_at_q;
        since_sent   = t - join_sent_q;
        since_join   = t - join_at_q;
        case (phase_q)
            PC_BEACON:
            begin
                if (deadline_hit(t))
                    abort_session();
                else if (since_beacon >= BEACON_MS)
                begin
                    note_result(KIND_BEACON, leader_q, DEST_BCAST, '0, leader_q);
                    if (ok)
                        beacon_at_q = t;
                end
            end
            PC_SCAN:
            begin
                if (deadline_hit(t))
                    abort_session();
            end
            PC_JOINSENT:
            begin
                // hold time and expiry are both checked on the same tick
                if (since_sent >= HOLD_MS)
                    enter_phase(PC_WAITKEY, '0);
                if (deadline_hit(t))
                    abort_session();
            end
            PC_WAITKEY:
            begin
                if (deadline_hit(t))
                    abort_session();
                else if (leader_mac_ok_q && since_join >= RETRY_MS && tries_q < RETRY_LIMIT)
                    issue_join(t, ok);
            end
            default: ;
        endcase
    endfunction

    function automatic void run_pairing_event(input in_t it);
        have_held = 1'b0;
        case (it.opcode)
            OP_TICK:
                on_tick(it.now_ms, it.link_ok);
            OP_START_LEADER:
            begin
                // without a key the leader start is refused outright
                if (cfg_klen != 6'd0)
                begin
                    role_q      = ROLE_LEADER;
                    team_q      = cfg_team;
                    team_ok_q   = 1'b1;
                    key_q       = cfg_key;
                    leader_q    = cfg_leader;
                    deadline_q  = it.now_ms + WINDOW_MS;
                    beacon_at_q = '0;
                    tries_q     = '0;
                    join_sent_q = '0;
                    enter_phase(PC_BEACON, '0);
                end
            end
            OP_START_MEMBER:
            begin
                role_q          = ROLE_MEMBER;
                my_member_q     = cfg_member;
                leader_q        = '0;
                leader_mac_ok_q = 1'b0;
                team_ok_q       = 1'b0;
                key_q           = '0;
                nonce_q         = it.nonce_in;
                deadline_q      = it.now_ms + MEMBER_MS;
                join_at_q       = '0;
                tries_q         = '0;
                join_sent_q     = '0;
                enter_phase(PC_SCAN, '0);
            end
            OP_STOP:
                drop_to_idle();
            OP_BEACON_RX:
            begin
                if (role_q == ROLE_MEMBER &&
                    (phase_q == PC_SCAN || phase_q == PC_JOINSENT || phase_q == PC_WAITKEY))
                begin
                    team_q          = it.frame_team_id;
                    team_ok_q       = 1'b1;
                    key_q           = it.frame_key_id;
                    leader_q        = it.frame_leader_id;
                    leader_mac_q    = it.sender_addr;
                    leader_mac_ok_q = 1'b1;
                    nonce_q         = it.nonce_in;
                    tries_q         = '0;
                    issue_join(it.now_ms, it.link_ok);
                    join_sent_q = it.now_ms;
                    enter_phase(PC_JOINSENT, '0);
                end
            end
            OP_JOIN_RX:
            begin
                if (role_q == ROLE_LEADER && phase_q == PC_BEACON && team_ok_q &&
                    it.frame_team_id == team_q)
                begin
                    note_result(KIND_KEY, it.frame_member_id, it.sender_addr, it.nonce_in,
                                leader_q);
                    // refused key frame: no state event follows
                    if (it.link_ok)
                        note_result(KIND_STATE, it.frame_member_id, '0, '0, '0);
                end
            end
            OP_KEY_RX:
            begin
                if (role_q == ROLE_MEMBER && (phase_q == PC_WAITKEY || phase_q == PC_JOINSENT) &&
                    team_ok_q && it.frame_team_id == team_q && it.nonce_in == nonce_q)
                begin
                    key_q = it.frame_key_id;
                    note_result(KIND_INSTALLED, leader_q, '0, '0, leader_q);
                    enter_phase(PC_DONE, leader_q);
                    drop_to_idle();
                end
            end
            default: ;
        endcase
        if (have_held)
        begin
            held_res.last = 1'b1;
            outbox_q.push_back(held_res);
            have_held = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Event driver: bursts of random length, random gaps between them.
    // A stalled transaction stays on the wire untouched.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                run_pairing_event(on_wire);
                accepted_cnt++;
                item_on_wire = 1'b0;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (event_q.size() > 0)
                begin
                    on_wire = event_q.pop_front();
                    item_on_wire = 1'b1;
                    opcode          <= on_wire.opcode;
                    now_ms          <= on_wire.now_ms;
                    nonce_in        <= on_wire.nonce_in;
                    frame_team_id   <= on_wire.frame_team_id;
                    frame_key_id    <= on_wire.frame_key_id;
                    frame_leader_id <= on_wire.frame_leader_id;
                    frame_member_id <= on_wire.frame_member_id;
                    sender_addr     <= on_wire.sender_addr;
                    link_ok         <= on_wire.link_ok;
                    in_valid        <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        // a quarter of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: a random pattern, redrawn whenever its run ends, plus
    // one long hold-off so the result queue fills and the input stalls.
    // ------------------------------------------------------------------
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!held_once && accepted_cnt >= HOLD_AFTER)
        begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= mode_left[1];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result transaction against the oldest
    // owed one.
    // ------------------------------------------------------------------
    function automatic void note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic string bad_fields(input res_t want, input res_t seen);
        string s;
        s = "";
        if (seen.kind !== want.kind)             s = {s, " kind"};
        if (seen.role !== want.role)             s = {s, " role"};
        if (seen.phase !== want.phase)           s = {s, " phase"};
        if (seen.peer_id !== want.peer_id)       s = {s, " peer_id"};
        if (seen.team_id !== want.team_id)       s = {s, " team_id"};
        if (seen.team_known !== want.team_known) s = {s, " team_known"};
        if (seen.key_id !== want.key_id)         s = {s, " key_id"};
        if (seen.dest_addr !== want.dest_addr)   s = {s, " dest_addr"};
        if (seen.nonce !== want.nonce)           s = {s, " nonce"};
        if (seen.leader_id !== want.leader_id)   s = {s, " leader_id"};
        if (seen.last !== want.last)             s = {s, " last"};
        return s;
    endfunction

    always @(posedge clk)
    begin : result_check
        res_t  seen;
        res_t  want;
        string bad;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {result_kind, role_out, phase_out, peer_id_out, team_id_out, team_known_out,
                    key_id_out, dest_addr, nonce_out, leader_id_out, last_out};
            if (outbox_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result %h at %0t", seen, $realtime));
            end
            else
            begin
                want = outbox_q.pop_front();
                bad = bad_fields(want, seen);
                if (bad != "")
                    note_failure($sformatf("mismatch in%s at %0t: expected %h, got %h",
                                           bad, $realtime, want, seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Event with every field random and the time taken from the time base.
    function automatic in_t fresh(input logic [2:0] op);
        in_t         it;
        logic [63:0] w;
        it.opcode          = op;
        it.now_ms          = ms_clock;
        it.nonce_in        = $urandom;
        it.frame_team_id   = {$urandom, $urandom};
        it.frame_key_id    = $urandom;
        it.frame_leader_id = $urandom;
        it.frame_member_id = $urandom;
        w = {$urandom, $urandom};
        it.sender_addr     = w[47:0];
        it.link_ok         = ($urandom_range(0, 4) != 0);
        return it;
    endfunction

    task automatic send(input in_t it);
        event_q.push_back(it);
        if (it.opcode != OP_UNUSED)
            items_made++;
    endtask

    task automatic tick_at(input logic [31:0] t, input logic ok);
        in_t it;
        ms_clock = t;
        it = fresh(OP_TICK);
        it.link_ok = ok;
        send(it);
    endtask

    // Config writes go in only while nothing is in flight.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic load_settings(input logic [63:0] team, input logic [31:0] key,
                                 input logic [31:0] lead, input logic [31:0] mem,
                                 input logic [5:0] klen);
        put_reg(CFG_LEADER_TEAM_ID, team);
        put_reg(CFG_LEADER_KEY_ID, {32'd0, key});
        put_reg(CFG_LEADER_NODE_ID, {32'd0, lead});
        put_reg(CFG_MEMBER_NODE_ID, {32'd0, mem});
        put_reg(CFG_KEY_LENGTH, {58'd0, klen});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_team   = team;
        cfg_key    = key;
        cfg_leader = lead;
        cfg_member = mem;
        cfg_klen   = klen;
    endtask

    // Wait for every event to go in and every owed result to come out, then
    // give the pipeline time to show anything extra.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (event_q.size() != 0 || item_on_wire || outbox_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Key length zero: leader start refused, frames in the wrong role dropped.
    task automatic directed_refusals();
        ms_clock = 32'd1000;
        send(fresh(OP_START_LEADER));
        send(fresh(OP_TICK));
        send(fresh(OP_UNUSED));
        send(fresh(OP_JOIN_RX));
        send(fresh(OP_KEY_RX));
        send(fresh(OP_BEACON_RX));
        send(fresh(OP_STOP));
    endtask

    // All-ones configuration, key length 32.
    task automatic directed_handshake();
        in_t         it;
        logic [31:0] t0;

        // leader start whose window wraps to a zero deadline: it never expires
        t0 = 32'd0 - WINDOW_MS;
        ms_clock = t0;
        send(fresh(OP_START_LEADER));
        tick_at(t0 + 32'd200000, 1'b0);      // beacon, refused: send time kept
        tick_at(t0 + 32'd200010, 1'b1);      // beacon again, accepted
        tick_at(t0 + 32'd200110, 1'b1);      // inside the beacon interval
        it = fresh(OP_JOIN_RX);
        it.frame_team_id = cfg_team;
        it.link_ok = 1'b1;
        send(it);                            // key frame and state event
        it = fresh(OP_JOIN_RX);
        it.frame_team_id = cfg_team;
        it.link_ok = 1'b0;
        send(it);                            // refused key frame alone
        it = fresh(OP_JOIN_RX);
        it.frame_team_id = '0;
        send(it);                            // wrong team
        send(fresh(OP_STOP));

        // member with a zero deadline, beacon with every field at all ones
        t0 = 32'd0 - MEMBER_MS;
        ms_clock = t0;
        it = fresh(OP_START_MEMBER);
        it.nonce_in = '0;
        send(it);
        it = '1;
        it.opcode = OP_BEACON_RX;
        it.now_ms = t0 + 32'd5;
        it.link_ok = 1'b0;
        send(it);                            // join refused, tries untouched
        tick_at(t0 + 32'd805, 1'b1);         // hold over: waiting for key
        tick_at(t0 + 32'd2305, 1'b1);        // join retry
        tick_at(t0 + 32'd2315, 1'b1);        // too soon for another
        it = fresh(OP_KEY_RX);
        it.frame_team_id = '1;
        it.nonce_in = 32'hFFFF_FFFE;
        send(it);                            // wrong nonce
        it = fresh(OP_KEY_RX);
        it.frame_team_id = 64'hFFFF_FFFF_FFFF_FFFE;
        it.nonce_in = '1;
        send(it);                            // wrong team
        it = fresh(OP_KEY_RX);
        it.frame_team_id = '1;
        it.nonce_in = '1;
        send(it);                            // installed, done, idle

        // beacon with every field zero, then hold and expiry on one tick
        ms_clock = 32'd1000;
        send(fresh(OP_START_MEMBER));
        it = '0;
        it.opcode = OP_BEACON_RX;
        it.now_ms = 32'd1100;
        send(it);
        tick_at(32'd40000, 1'b1);            // waiting for key, failed, idle

        ms_clock = 32'd50000;
        send(fresh(OP_START_MEMBER));
        tick_at(32'd90000, 1'b1);            // scan expiry
        ms_clock = 32'd100000;
        send(fresh(OP_START_LEADER));
        tick_at(32'd300000, 1'b1);           // leader window expiry
        send(fresh(OP_KEY_RX));
        send(fresh(OP_STOP));
    endtask

    task automatic jump_clock();
        if ($urandom_range(0, 7) == 0)
            ms_clock = $urandom;
        else
            ms_clock += $urandom_range(0, 5000);
    endtask

    task automatic leader_session();
        in_t it;
        int  steps;
        jump_clock();
        send(fresh(OP_START_LEADER));
        steps = $urandom_range(2, 10);
        repeat (steps)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    ms_clock += $urandom_range(0, 1300);
                    send(fresh(OP_TICK));
                end
                4, 5, 6, 7:
                begin
                    it = fresh(OP_JOIN_RX);
                    if ($urandom_range(0, 4) != 0)
                        it.frame_team_id = cfg_team;
                    send(it);
                end
                8:
                begin
                    ms_clock += $urandom_range(100000, 140000);
                    send(fresh(OP_TICK));
                end
                default:
                    send(fresh(($urandom_range(0, 1) == 0) ? OP_STOP : OP_BEACON_RX));
            endcase
        end
    endtask

    task automatic member_session();
        in_t         it;
        logic [63:0] team;
        logic [31:0] nonce;
        int          ticks;
        bit          steady;
        jump_clock();
        send(fresh(OP_START_MEMBER));
        repeat ($urandom_range(0, 2))
        begin
            ms_clock += $urandom_range(0, 3000);
            send(fresh(OP_TICK));
        end
        // a second beacon now and then restarts the join
        repeat ($urandom_range(0, 5) == 0 ? 2 : 1)
        begin
            it = fresh(OP_BEACON_RX);
            team = it.frame_team_id;
            nonce = it.nonce_in;
            send(it);
        end
        // steady retry spacing walks the try count up to its limit
        ticks = $urandom_range(0, 9);
        steady = ($urandom_range(0, 2) == 0);
        repeat (ticks)
        begin
            ms_clock += steady ? $urandom_range(1500, 1900) : $urandom_range(0, 2000);
            send(fresh(OP_TICK));
        end
        if ($urandom_range(0, 6) == 0)
        begin
            ms_clock += $urandom_range(30000, 40000);
            send(fresh(OP_TICK));
        end
        it = fresh(OP_KEY_RX);
        if ($urandom_range(0, 7) != 0)
            it.frame_team_id = team;
        if ($urandom_range(0, 7) != 0)
            it.nonce_in = nonce;
        send(it);
        if ($urandom_range(0, 3) == 0)
            send(fresh(OP_STOP));
    endtask

    task automatic noise_burst();
        in_t it;
        repeat ($urandom_range(1, 3))
        begin
            it = fresh(3'($urandom_range(0, 7)));
            if ($urandom_range(0, 1) == 0)
                it.now_ms = $urandom;
            send(it);
        end
    endtask

    task automatic random_sessions(input int n);
        int target;
        target = items_made + n;
        while (items_made < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: leader_session();
                4, 5, 6, 7: member_session();
                default:    noise_burst();
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [63:0] team;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        load_settings('0, '0, '0, '0, 6'd0);
        directed_refusals();
        wait_drained();

        load_settings('1, '1, '1, '1, 6'd32);
        directed_handshake();
        wait_drained();

        // random phases, each under its own configuration; the drain between
        // them is also the sender's pause until every result is back
        for (int p = 0; p < 3; p++)
        begin
            team = {$urandom, $urandom};
            load_settings(team, $urandom, $urandom, $urandom,
                          (p == 0) ? 6'd31 : 6'($urandom_range(1, 32)));
            random_sessions(100);
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("pairing_handshake_controller_tb passed");
        else
            $display("pairing_handshake_controller_tb failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("pairing_handshake_controller_tb failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/phc_pkg.sv
hdl/phc_engine.sv
hdl/pairing_handshake_controller.sv
tb/sv/pairing_handshake_controller_tb.sv
